// ===== rtl/jkmd_pkg.sv =====
// Package for the Jackson kernel moment damper: item and queue entry types,
// the configuration register file layout, state machine codes and rounding helpers.
// Used by every module under rtl; it depends on nothing else.
package jkmd_pkg;

  // Configuration register indexes on the write port.
  typedef enum logic [2:0] {
    REG_KEPT_MOMENTS = 3'd0,
    REG_COS_STEP     = 3'd1,
    REG_SIN_STEP     = 3'd2,
    REG_COT_STEP     = 3'd3,
    REG_NORM_FACTOR  = 3'd4
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // One in Q1.30.
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Input item.
  typedef struct packed {
    logic signed [31:0] moment_value;
    logic               start_of_set;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] damped_moment;
    logic [15:0]        moment_index;
  } out_item_t;

  // Configuration registers as the datapath sees them.
  typedef struct packed {
    logic [15:0]        kept_moments;
    logic signed [31:0] cos_step;
    logic [30:0]        sin_step;
    logic [30:0]        cot_step;
    logic [31:0]        norm_factor;
  } cfg_t;

  // A classified moment handed from the front to the back.
  typedef struct packed {
    logic signed [31:0] moment;
    logic [15:0]        out_index;
    logic               damp;
    logic [16:0]        delta;
    logic signed [31:0] cos_val;
    logic signed [31:0] sin_val;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_RND,
    F_UPD
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DELTA,
    B_SIN,
    B_ACC,
    B_ABS,
    B_NLO,
    B_NHI,
    B_WSUM,
    B_RLO,
    B_RHI,
    B_RSUM,
    B_SEND
  } back_state_t;

  // Drop sh fraction bits, rounding half away from zero.
  function automatic logic signed [65:0] round_away(input logic signed [65:0] v,
                                                    input int unsigned sh);
    logic [65:0] mag;
    logic [65:0] half;
    mag  = v[65] ? 66'(-v) : 66'(v);
    half = 66'(1) << (sh - 1);
    mag  = (mag + half) >> sh;
    return v[65] ? -$signed(mag) : $signed(mag);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/jkmd_queue.sv =====
// Two-entry queue between the damper's front and back parts.
// Depends on jkmd_pkg for the entry type and depth constants.
module jkmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jkmd_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output jkmd_pkg::q_entry_t head_entry
);
  import jkmd_pkg::*;

  q_entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_CNT_W-1:0]   count;

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/jkmd_front.sv =====
// Front part of the damper: accepts moments, tracks the index and runs the
// cos/sin rotation recurrence, then queues each classified item for the back.
// Depends on jkmd_pkg.
module jkmd_front #(
  parameter int INDEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  jkmd_pkg::cfg_t     cfg,
  input  logic               moment_valid,
  output logic               moment_stall,
  input  jkmd_pkg::in_item_t moment,
  output logic               push,
  output jkmd_pkg::q_entry_t push_entry,
  input  logic               queue_full
);
  import jkmd_pkg::*;

  localparam int CMP_W = (INDEX_BITS > 16) ? INDEX_BITS : 16;

  front_state_t             state;
  front_state_t             state_next;
  logic                     accept;

  logic [INDEX_BITS-1:0]    index_counter;
  logic signed [31:0]       cos_accum;
  logic signed [31:0]       sin_accum;
  logic signed [31:0]       moment_reg;

  logic signed [63:0]       p_cc;
  logic signed [63:0]       p_ss;
  logic signed [63:0]       p_sc;
  logic signed [63:0]       p_cs;
  logic signed [33:0]       r_cc;
  logic signed [33:0]       r_ss;
  logic signed [33:0]       r_sc;
  logic signed [33:0]       r_cs;

  logic [CMP_W-1:0]         m_ext;
  logic [CMP_W-1:0]         n_ext;
  logic signed [32:0]       sin_step_s;

  assign accept     = moment_valid && !moment_stall;
  assign m_ext      = CMP_W'(index_counter);
  assign n_ext      = CMP_W'(cfg.kept_moments);
  assign sin_step_s = {2'b00, cfg.sin_step};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = F_MUL;
        end
      end
      F_MUL:   state_next = F_RND;
      F_RND:   state_next = F_UPD;
      F_UPD:   state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs: stall while an item is in flight or the queue has no room.
  always_comb begin
    moment_stall = 1'b1;
    push         = 1'b0;
    unique case (state)
      F_IDLE:  moment_stall = queue_full;
      F_MUL:   push = 1'b1;
      F_RND:   moment_stall = 1'b1;
      F_UPD:   moment_stall = 1'b1;
      default: moment_stall = 1'b1;
    endcase
  end

  // Classified entry: damping applies below the kept moment count.
  always_comb begin
    push_entry.moment    = moment_reg;
    push_entry.out_index = 16'(index_counter);
    push_entry.damp      = (m_ext < n_ext);
    push_entry.delta     = 17'(cfg.kept_moments) - 17'(index_counter) + 17'd1;
    push_entry.cos_val   = cos_accum;
    push_entry.sin_val   = sin_accum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Index counter and recurrence state; a start flag restarts them at index zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      index_counter <= '0;
      cos_accum     <= Q30_ONE;
      sin_accum     <= '0;
    end else begin
      if (accept && moment.start_of_set) begin
        index_counter <= '0;
        cos_accum     <= Q30_ONE;
        sin_accum     <= '0;
      end
      if (state == F_MUL && index_counter != '1) begin
        index_counter <= index_counter + 1'b1;
      end
      if (state == F_UPD) begin
        cos_accum <= sat32(36'(r_cc) - 36'(r_ss));
        sin_accum <= sat32(36'(r_sc) + 36'(r_cs));
      end
    end
  end

  // Rotation products, then their rounding to Q1.30.
  always_ff @(posedge clk) begin
    if (accept) begin
      moment_reg <= moment.moment_value;
    end
    if (state == F_MUL) begin
      p_cc <= cos_accum * cfg.cos_step;
      p_ss <= 64'(33'(sin_accum) * sin_step_s);
      p_sc <= sin_accum * cfg.cos_step;
      p_cs <= 64'(33'(cos_accum) * sin_step_s);
    end
    if (state == F_RND) begin
      r_cc <= 34'(round_away(66'(p_cc), 30));
      r_ss <= 34'(round_away(66'(p_ss), 30));
      r_sc <= 34'(round_away(66'(p_sc), 30));
      r_cs <= 34'(round_away(66'(p_cs), 30));
    end
  end

endmodule

// ===== rtl/jkmd_back.sv =====
// Back part of the damper: computes the Jackson weight and the damped moment
// on one shared multiplier, then holds the result in the output register.
// Depends on jkmd_pkg.
module jkmd_back (
  input  logic                clk,
  input  logic                rst,
  input  jkmd_pkg::cfg_t      cfg,
  input  logic                head_valid,
  input  jkmd_pkg::q_entry_t  head_entry,
  output logic                pop,
  output logic                damped_valid,
  input  logic                damped_stall,
  output jkmd_pkg::out_item_t damped
);
  import jkmd_pkg::*;

  back_state_t          state;
  back_state_t          state_next;

  q_entry_t             cur;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   prod;
  logic signed [48:0]   sum;
  logic [47:0]          smag;
  logic                 wneg;
  logic [47:0]          w;
  logic [33:0]          part;
  logic signed [31:0]   res;
  logic                 load_out;

  logic                 mneg;
  logic [31:0]          mmag;
  logic signed [65:0]   cot_rnd;
  logic [49:0]          r;
  logic signed [31:0]   r_sat;

  assign mneg = cur.moment[31];
  assign mmag = mneg ? 32'(-33'(cur.moment)) : 32'(cur.moment);

  // Final product magnitude, signed and saturated.
  always_comb begin
    cot_rnd = round_away(prod, 16);
    r       = {prod[47:0], 2'b00} + 50'(part);
    if (mneg != wneg) begin
      r_sat = (r > 50'h0_8000_0000) ? 32'sh8000_0000 : 32'(-$signed(51'(r)));
    end else begin
      r_sat = (r > 50'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          state_next = head_entry.damp ? B_DELTA : B_SEND;
        end
      end
      B_DELTA: state_next = B_SIN;
      B_SIN:   state_next = B_ACC;
      B_ACC:   state_next = B_ABS;
      B_ABS:   state_next = B_NLO;
      B_NLO:   state_next = B_NHI;
      B_NHI:   state_next = B_WSUM;
      B_WSUM:  state_next = B_RLO;
      B_RLO:   state_next = B_RHI;
      B_RHI:   state_next = B_RSUM;
      B_RSUM:  state_next = B_SEND;
      B_SEND: begin
        if (load_out) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs: queue pop, output load and multiplier operands.
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      B_IDLE:  pop = head_valid;
      B_DELTA: begin
        mul_a = {16'b0, cur.delta};
        mul_b = {cur.cos_val[31], cur.cos_val};
      end
      B_SIN: begin
        mul_a = {cur.sin_val[31], cur.sin_val};
        mul_b = {2'b00, cfg.cot_step};
      end
      B_NLO: begin
        mul_a = {1'b0, smag[31:0]};
        mul_b = {1'b0, cfg.norm_factor};
      end
      B_NHI: begin
        mul_a = {17'b0, smag[47:32]};
        mul_b = {1'b0, cfg.norm_factor};
      end
      B_RLO: begin
        mul_a = {1'b0, mmag};
        mul_b = {1'b0, w[31:0]};
      end
      B_RHI: begin
        mul_a = {1'b0, mmag};
        mul_b = {17'b0, w[47:32]};
      end
      B_SEND:  load_out = !damped_valid || !damped_stall;
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Weight datapath: Q.30 sum, magnitude, normalization, then moment product.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      B_IDLE: begin
        cur <= head_entry;
        res <= head_entry.moment;
      end
      B_SIN:  sum <= prod[48:0];
      B_ACC:  sum <= sum + cot_rnd[48:0];
      B_ABS: begin
        smag <= sum[48] ? 48'(-sum) : sum[47:0];
        wneg <= sum[48];
      end
      B_NHI:  part <= 34'((prod[63:0] + 64'h0000_0000_8000_0000) >> 32);
      B_WSUM: w <= prod[47:0] + 48'(part);
      B_RHI:  part <= 34'((prod[63:0] + 64'h0000_0000_2000_0000) >> 30);
      B_RSUM: res <= r_sat;
      default: begin
      end
    endcase
  end

  // Output register; it frees as soon as the receiver takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      damped_valid <= 1'b0;
    end else if (load_out) begin
      damped_valid <= 1'b1;
    end else if (!damped_stall) begin
      damped_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      damped.damped_moment <= res;
      damped.moment_index  <= cur.out_index;
    end
  end

endmodule

// ===== rtl/jackson_kernel_moment_damper.sv =====
// Top level of the Jackson kernel moment damper: configuration registers,
// front part, queue and back part. Depends on jkmd_pkg and the jkmd_* modules.
//
// Usage:
//   Moments enter on the moment channel (moment_valid / moment_stall), in index
//   order; start_of_set marks index zero and restarts the cos/sin recurrence.
//   Each moment yields exactly one item on the damped channel (damped_valid /
//   damped_stall): the moment times its Jackson weight, or the moment itself
//   when its index is at or beyond kept_moments, with its index.
//   The front takes no new moment until the recurrence update (multiply,
//   round, add) for the last one is done. A damped moment holds the back
//   through its weight states on its single shared multiplier, which then sets
//   the sustained rate; a passed moment only passes the back's IDLE and SEND
//   states, so the front sets its rate.
//   A two-entry queue lets the front run ahead; when the receiver stalls, the
//   result holds in the output register, the back waits, the queue fills and
//   then moment_stall rises. The user must write registers through cfg_we /
//   cfg_index / cfg_data only while idle; the block itself does not enforce it.
//   Synchronous reset restores register defaults, index zero, cos = 1, sin = 0.
module jackson_kernel_moment_damper #(
  parameter int INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                moment_valid,
  output logic                                moment_stall,
  input  jkmd_pkg::in_item_t                  moment,
  output logic                                damped_valid,
  input  logic                                damped_stall,
  output jkmd_pkg::out_item_t                 damped,
  input  logic                                cfg_we,
  input  logic [jkmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jkmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jkmd_pkg::*;

  cfg_t     cfg;
  logic     push;
  q_entry_t push_entry;
  logic     queue_full;
  logic     pop;
  logic     head_valid;
  q_entry_t head_entry;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kept_moments <= 16'd1;
      cfg.cos_step     <= '0;
      cfg.sin_step     <= 31'h4000_0000;
      cfg.cot_step     <= '0;
      cfg.norm_factor  <= 32'h8000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEPT_MOMENTS: cfg.kept_moments <= cfg_data[15:0];
        REG_COS_STEP:     cfg.cos_step     <= $signed(cfg_data);
        REG_SIN_STEP:     cfg.sin_step     <= cfg_data[30:0];
        REG_COT_STEP:     cfg.cot_step     <= cfg_data[30:0];
        REG_NORM_FACTOR:  cfg.norm_factor  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  jkmd_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .moment_valid (moment_valid),
    .moment_stall (moment_stall),
    .moment       (moment),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  jkmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  jkmd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .damped_valid (damped_valid),
    .damped_stall (damped_stall),
    .damped       (damped)
  );

endmodule

// ===== dv/jkmd_result_checker.sv =====
// Result checker for the Jackson kernel moment damper: predicts every damped item
// from the accepted moments and register writes, and compares it with the output.
// Depends on jkmd_pkg for the item types and the register indexes.
module jkmd_result_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             moment_valid,
  input  logic                             moment_stall,
  input  jkmd_pkg::in_item_t               moment,
  input  logic                             damped_valid,
  input  logic                             damped_stall,
  input  jkmd_pkg::out_item_t              damped,
  input  logic                             cfg_we,
  input  logic [jkmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jkmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatch_total,
  output int                               items_due,
  output int                               results_checked,
  output int                               results_weighted
);
  import jkmd_pkg::*;

  localparam longint INDEX_LIMIT = 65535;
  localparam int REPORT_CAP = 200;

  // Local copy of the register file.
  longint kept_n;
  longint cos_step_q;
  longint sin_step_q;
  longint cot_step_q;
  longint norm_q;

  // Moment index and the cos/sin rotation state.
  longint index_n;
  longint cos_q;
  longint sin_q;

  out_item_t damped_due[$];
  int fails = 0;
  int checks = 0;
  int weighted = 0;

  // Drop sh fraction bits, rounding half away from zero.
  function automatic longint round_off(input longint v, input int sh);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) begin
      return -longint'(mag);
    end
    return longint'(mag);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Works out the damped item for one moment and advances the recurrence.
  task automatic damp_next(input in_item_t it, output out_item_t res);
    longint mval;
    longint sum;
    longint c;
    longint s;
    logic [127:0] smag;
    logic [127:0] w;
    logic [127:0] mmag;
    logic [127:0] r;
    logic [31:0] r32;
    bit wneg;
    bit mneg;
    mval = longint'($signed(it.moment_value));
    if (it.start_of_set) begin
      index_n = 0;
      cos_q = longint'(Q30_ONE);
      sin_q = 0;
    end
    res.moment_index = index_n[15:0];
    res.damped_moment = it.moment_value;

    // Moments below N get the Jackson weight; the rest pass unchanged.
    if (index_n < kept_n) begin
      weighted++;
      sum = (kept_n - index_n + 1) * cos_q + round_off(sin_q * cot_step_q, 16);
      wneg = sum < 0;
      smag = wneg ? 128'(-sum) : 128'(sum);
      w = (smag * 128'(norm_q) + (128'd1 << 31)) >> 32;
      mneg = mval < 0;
      mmag = mneg ? 128'(-mval) : 128'(mval);
      r = (mmag * w + (128'd1 << 29)) >> 30;
      if (mneg != wneg) begin
        if (r > (128'd1 << 31)) begin
          r = 128'd1 << 31;
        end
        r32 = r[31:0];
        res.damped_moment = -r32;
      end else begin
        if (r > 128'h7FFF_FFFF) begin
          r = 128'h7FFF_FFFF;
        end
        res.damped_moment = r[31:0];
      end
    end

    // The rotation advances on every moment, damped or not.
    c = cos_q;
    s = sin_q;
    cos_q = clamp32(round_off(c * cos_step_q, 30) - round_off(s * sin_step_q, 30));
    sin_q = clamp32(round_off(s * cos_step_q, 30) + round_off(c * sin_step_q, 30));
    if (index_n < INDEX_LIMIT) begin
      index_n++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      kept_n = 1;
      cos_step_q = 0;
      sin_step_q = longint'(Q30_ONE);
      cot_step_q = 0;
      norm_q = 64'sd2147483648;
      index_n = 0;
      cos_q = longint'(Q30_ONE);
      sin_q = 0;
      damped_due.delete();
    end else begin
      // Register writes update the local copy.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEPT_MOMENTS: kept_n = longint'(cfg_data[15:0]);
          REG_COS_STEP:     cos_step_q = longint'($signed(cfg_data));
          REG_SIN_STEP:     sin_step_q = longint'(cfg_data[30:0]);
          REG_COT_STEP:     cot_step_q = longint'(cfg_data[30:0]);
          REG_NORM_FACTOR:  norm_q = longint'(cfg_data);
          default: ;
        endcase
      end

      // Each accepted moment queues one expected item.
      if (moment_valid && !moment_stall) begin
        damp_next(moment, want);
        damped_due.push_back(want);
      end

      // Each accepted result is matched against the oldest expectation.
      if (damped_valid && !damped_stall) begin
        checks++;
        if (damped_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP) begin
            $display("%0t: unexpected item: damped_moment %0d, moment_index %0d",
                     $time, damped.damped_moment, damped.moment_index);
          end
        end else begin
          want = damped_due.pop_front();
          if (damped.damped_moment !== want.damped_moment) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              $display("%0t: damped_moment at index %0d: expected %0d, got %0d",
                       $time, want.moment_index, want.damped_moment, damped.damped_moment);
            end
          end
          if (damped.moment_index !== want.moment_index) begin
            fails++;
            if (fails <= REPORT_CAP) begin
              $display("%0t: moment_index: expected %0d, got %0d",
                       $time, want.moment_index, damped.moment_index);
            end
          end
        end
        if (fails > REPORT_CAP && fails - REPORT_CAP <= 2) begin
          $display("%0t: further mismatches are counted but not printed", $time);
        end
      end
    end
    mismatch_total <= fails;
    items_due <= damped_due.size();
    results_checked <= checks;
    results_weighted <= weighted;
  end

endmodule

// ===== dv/jackson_kernel_moment_damper_tb.sv =====
// Testbench top for the Jackson kernel moment damper: clock, reset, register
// settings, moment stimulus with idling and stalls, and the verdict.
// Depends on jkmd_pkg, the block under test and jkmd_result_checker.
module jackson_kernel_moment_damper_tb;
  import jkmd_pkg::*;

  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS = 140;
  localparam int RANDOM_PHASES = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic moment_valid = 1'b0;
  logic moment_stall;
  in_item_t moment = '0;
  logic damped_valid;
  logic damped_stall = 1'b0;
  out_item_t damped;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_gap_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int settings_loaded = 0;
  int cycle_count;
  int mismatches;
  int pending;
  int results_seen;
  int weighted_seen;

  always #5 clk = ~clk;

  jackson_kernel_moment_damper dut (
    .clk(clk),
    .rst(rst),
    .moment_valid(moment_valid),
    .moment_stall(moment_stall),
    .moment(moment),
    .damped_valid(damped_valid),
    .damped_stall(damped_stall),
    .damped(damped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  jkmd_result_checker results_chk (
    .clk(clk),
    .rst(rst),
    .moment_valid(moment_valid),
    .moment_stall(moment_stall),
    .moment(moment),
    .damped_valid(damped_valid),
    .damped_stall(damped_stall),
    .damped(damped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_total(mismatches),
    .items_due(pending),
    .results_checked(results_seen),
    .results_weighted(weighted_seen)
  );

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d items outstanding.", RUN_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        damped_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        damped_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 72; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 72; end
      default:       begin send_gap_pct = 14; stall_pct = 14; end
    endcase
  endtask

  task automatic put_reg(input cfg_reg_t r, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Writes the whole register file in consecutive cycles.
  task automatic load_settings(input logic [15:0] kept, input logic [31:0] cos_v,
                               input logic [31:0] sin_v, input logic [31:0] cot_v,
                               input logic [31:0] norm_v);
    put_reg(REG_KEPT_MOMENTS, {16'd0, kept});
    put_reg(REG_COS_STEP, cos_v);
    put_reg(REG_SIN_STEP, sin_v);
    put_reg(REG_COT_STEP, cot_v);
    put_reg(REG_NORM_FACTOR, norm_v);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Constants as software derives them for a kernel of n moments.
  task automatic load_jackson(input int unsigned n);
    real phi;
    real c;
    real s;
    phi = 3.141592653589793 / (n + 1);
    c = $cos(phi);
    s = $sin(phi);
    load_settings(n[15:0], 32'(longint'(c * 1073741824.0)), 32'(longint'(s * 1073741824.0)),
                  32'(longint'(c / s * 65536.0)), 32'(longint'(4294967296.0 / (n + 1))));
  endtask

  // Waits until every expected item has come out.
  task automatic drain();
    moment_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Offers one moment after a random gap and holds it until accepted.
  task automatic offer(input logic [31:0] value, input bit start);
    in_item_t it;
    it.moment_value = value;
    it.start_of_set = start;
    while ($urandom_range(99) < send_gap_pct) begin
      moment_valid <= 1'b0;
      @(posedge clk);
    end
    moment_valid <= 1'b1;
    moment <= it;
    do @(posedge clk); while (moment_stall);
  endtask

  function automatic logic [31:0] pick_moment();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  // One set of moments, usually opened by the start flag.
  task automatic send_set(input int len, input bit with_start);
    for (int i = 0; i < len; i++) begin
      offer(pick_moment(), (with_start && i == 0) || ($urandom_range(99) < 2));
    end
  endtask

  initial begin
    int sent;
    int span;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset registers and state, without a start flag.
    offer(32'h2000_0000, 1'b0);
    offer(32'hE000_0000, 1'b0);

    // Directed: field extremes with a realistic kernel, past N, then a restart.
    drain();
    load_jackson(8);
    offer(32'h7FFF_FFFF, 1'b1);
    offer(32'h8000_0000, 1'b0);
    offer(32'h0000_0000, 1'b0);
    offer(32'h0000_0001, 1'b0);
    offer(32'hFFFF_FFFF, 1'b0);
    offer(Q30_ONE, 1'b0);
    offer(-Q30_ONE, 1'b0);
    repeat (4) offer(pick_moment(), 1'b0);
    offer(32'h7FFF_FFFF, 1'b1);
    offer(32'h8000_0000, 1'b0);
    offer(pick_moment(), 1'b0);

    // Directed: nothing damped when N is zero.
    drain();
    load_settings(16'd0, 32'h3000_0000, 32'h1000_0000, 32'h0001_0000, 32'h1000_0000);
    offer(32'h7FFF_FFFF, 1'b1);
    offer(32'h8000_0000, 1'b0);
    offer(pick_moment(), 1'b0);

    // Directed: extreme registers drive the product into saturation.
    drain();
    load_settings(16'hFFFF, 32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(32'h7FFF_FFFF, 1'b1);
    offer(32'h8000_0000, 1'b0);
    offer(32'h7FFF_FFFF, 1'b0);
    offer(32'h0000_0001, 1'b0);

    // Random phases, each with its own settings and idle mix.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase == 5) begin
        span = $urandom_range(0, 40);
        load_settings(span[15:0], $urandom, $urandom, $urandom, $urandom);
        span += 4;
      end else if (phase == 6) begin
        load_settings(16'd1, 32'h4000_0000, 32'd0, 32'd0, 32'd0);
        span = 6;
      end else if (phase == 7) begin
        load_jackson(65535);
        span = 200;
      end else begin
        span = $urandom_range(1, 24);
        load_jackson(span);
        span += 4;
      end
      set_idle(idle_mode_t'(phase % 4));
      if (phase == 4) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, span);
        send_set(len, $urandom_range(9) != 0);
        sent += len;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d items over %0d register settings: %0d weighted, %0d passed through.",
             results_seen, settings_loaded, weighted_seen, results_seen - weighted_seen);
    $display("Stimulus mixed idling and stalls, restarts, saturation and one long hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
